[sv/fcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared widths, register map and the fault priority encoder for the
// fault-code LED flasher.
// ----------------------------------------------------------------------------
package fcl_pkg;

    localparam int FLAG_W          = 16;
    localparam int CODE_W          = 5;
    localparam int TOG_W           = 6;
    localparam int PAUSE_W         = 8;
    localparam int FAULT_BITS_DEF  = 16;

    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [PAUSE_W-1:0] PAUSE_RESET = 8'd10;

    // register index, taken from paddr above the byte lanes
    typedef enum logic [0:0] {
        REG_PAUSE_TICKS = 1'b0
    } t_reg_idx;

    // lowest set bit at position k gives code k+1; no bit gives code 0
    function automatic logic [CODE_W-1:0] fault_code(input logic [FLAG_W-1:0] flags);
        logic [CODE_W-1:0] code;
        code = '0;
        for (int k = FLAG_W - 1; k >= 0; k--) begin
            if (flags[k]) begin
                code = CODE_W'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

[sv/fcl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_if
// Valid/ready channels of the flasher: fault bitmap in, LED level out.
// ----------------------------------------------------------------------------
interface fcl_flags_if
    import fcl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FLAG_W-1:0] fault_flags;

    modport source (output valid, output fault_flags, input ready);
    modport sink   (input valid, input fault_flags, output ready);
endinterface

interface fcl_led_if
    import fcl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              led_on;
    logic [CODE_W-1:0] shown_code;

    modport source (output valid, output led_on, output shown_code, input ready);
    modport sink   (input valid, input led_on, input shown_code, output ready);
endinterface

[sv/fault_code_led_flasher.sv]
`timescale 1ns / 1ps
// Fault-code LED flasher. Every beat on i_flags is one flash tick carrying the
// active fault bitmap; every tick yields exactly one beat on o_led with the LED
// level after that tick and the blink code in use. The lowest set fault bit k
// selects code k+1 (bits at or above FAULT_BITS are ignored). With no fault the
// LED toggles every tick. With a fault the LED stays dark for pause_ticks ticks,
// then flashes the code (2*code toggles), goes dark and pauses again. Throughput
// is one tick per clock while o_led is not stalled; each tick passes two
// registers, the input register and the result register, with the state update
// between them. The pause register sits at APB byte address 0; the user must
// write it only while no tick is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
// fault_code_led_flasher
// Input register, single-pass blink state update, result register, APB
// configuration of the inter-burst pause.
// ----------------------------------------------------------------------------
module fault_code_led_flasher
    import fcl_pkg::*;
#(
    parameter int FAULT_BITS = FAULT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fcl_flags_if.sink             i_flags,
    fcl_led_if.source             o_led,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // only the low FAULT_BITS bits of the bitmap take part, capped at the port width
    localparam int LP_USED = (FAULT_BITS < FLAG_W) ? FAULT_BITS : FLAG_W;

    // ---- configuration ----------------------------------------------------
    logic [PAUSE_W-1:0] r_pause_ticks;
    t_reg_idx           cfg_idx;
    logic               cfg_hit;
    logic               cfg_wr;

    // decode the word index; byte lanes inside a word are don't-care
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == 1'(REG_PAUSE_TICKS));
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign pready  = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_PAUSE_TICKS: prdata = cfg_hit ? APB_DATA_W'(r_pause_ticks) : '0;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_ticks <= PAUSE_RESET;
        end else if (cfg_wr) begin
            r_pause_ticks <= pwdata[PAUSE_W-1:0];
        end
    end

    // ---- input register ---------------------------------------------------
    logic              r_in_valid;
    logic [FLAG_W-1:0] r_in_flags;
    logic              out_free;
    logic              advance;

    // a result slot is free when empty or being drained this cycle
    assign out_free      = !o_led.valid || o_led.ready;
    assign advance       = r_in_valid && out_free;
    assign i_flags.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_flags.ready) begin
            r_in_valid <= i_flags.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flags.valid && i_flags.ready) begin
            r_in_flags <= i_flags.fault_flags;
        end
    end

    // ---- blink state update -----------------------------------------------
    logic                r_led_level;
    logic [CODE_W-1:0]   r_blink_code;
    logic [TOG_W-1:0]    r_toggles_left;
    logic [PAUSE_W-1:0]  r_pause_left;

    logic                n_led_level;
    logic [CODE_W-1:0]   n_blink_code;
    logic [TOG_W-1:0]    n_toggles_left;
    logic [PAUSE_W-1:0]  n_pause_left;

    logic [FLAG_W-1:0]   flags_m;
    logic [TOG_W-1:0]    tog_load;

    always_comb begin
        for (int k = 0; k < FLAG_W; k++) begin
            flags_m[k] = (k < LP_USED) ? r_in_flags[k] : 1'b0;
        end
    end

    always_comb begin
        n_led_level    = r_led_level;
        n_blink_code   = r_blink_code;
        n_toggles_left = r_toggles_left;
        n_pause_left   = r_pause_left;
        tog_load       = r_toggles_left;

        // latch the highest-priority code, or drop to no fault and rearm the pause
        if (flags_m != '0) begin
            n_blink_code = fault_code(flags_m);
        end else begin
            n_blink_code = '0;
            n_pause_left = r_pause_ticks;
        end

        priority if (n_blink_code == '0) begin
            // idle heartbeat: toggle every tick
            n_led_level = !r_led_level;
        end else if (n_pause_left != '0) begin
            // dark gap between bursts
            n_pause_left = n_pause_left - 1'b1;
            n_led_level  = 1'b0;
        end else begin
            // start a burst from dark, or resume a burst left unfinished
            if (r_toggles_left == '0) begin
                tog_load    = {n_blink_code, 1'b0};
                n_led_level = 1'b1;
            end else begin
                n_led_level = !r_led_level;
            end
            n_toggles_left = tog_load - 1'b1;
            // burst done: force dark and rearm the pause
            if (n_toggles_left == '0) begin
                n_pause_left = r_pause_ticks;
                n_led_level  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_level    <= 1'b0;
            r_blink_code   <= '0;
            r_toggles_left <= '0;
            r_pause_left   <= '0;
        end else if (advance) begin
            r_led_level    <= n_led_level;
            r_blink_code   <= n_blink_code;
            r_toggles_left <= n_toggles_left;
            r_pause_left   <= n_pause_left;
        end
    end

    // ---- result register --------------------------------------------------
    logic              r_out_valid;
    logic              r_out_led;
    logic [CODE_W-1:0] r_out_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_led  <= n_led_level;
            r_out_code <= n_blink_code;
        end
    end

    assign o_led.valid      = r_out_valid;
    assign o_led.led_on     = r_out_led;
    assign o_led.shown_code = r_out_code;

`ifndef ASSERT_OFF
    // a latched code always names a fault bit in range
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink_code <= CODE_W'(LP_USED))
        else $error("blink code out of range");

    // a fault-free tick clears the code and rearms the pause
    a_clear_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && flags_m == '0) |=>
            (r_blink_code == '0 && r_pause_left == $past(r_pause_ticks)))
        else $error("fault-free tick did not rearm pause");

    // while the pause runs down the LED is dark in the result
    a_dark_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_blink_code != '0 && n_pause_left != '0) |=> !r_out_led)
        else $error("LED lit during pause");

    // a stalled result holds the input stage full
    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_flags.ready |-> (r_in_valid && o_led.valid && !o_led.ready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

[tb/tb_fault_code_led_flasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fault_code_led_flasher
// Self-checking bench for the fault-code LED flasher. A short scripted
// sequence covers the corner cases of the blink state machine. Random phases
// with different pause settings follow. Flash ticks go in on the flags
// channel, and every LED beat is checked against a cycle-free model of the
// blink state. Both channels idle and stall at random while idling is on.
// ----------------------------------------------------------------------------
module tb_fault_code_led_flasher;
    import fcl_pkg::*;

    localparam int LIMIT_NS     = 3_000_000;
    localparam int SETTLE_TICKS = 8;

    typedef struct packed {
        logic              led;
        logic [CODE_W-1:0] code;
    } t_led_beat;

    typedef enum logic {
        ROW_TICK  = 1'b0,
        ROW_PAUSE = 1'b1
    } t_row_kind;

    // one scripted step: a flash tick, or a write of the pause register
    typedef struct packed {
        t_row_kind         kind;
        logic [FLAG_W-1:0] value;
        logic              typed;
        logic              led;
        logic [CODE_W-1:0] code;
    } t_script_row;

    localparam int SCRIPT_LEN = 25;

    // typed results are the ones that follow from reset or from a fresh pause
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // first fault after reset, top code: pause is 0, so flash at once
        '{ROW_TICK,  16'h8000, 1'b1, 1'b1, 5'd16},
        // all bits set: code drops to 1 in mid-burst, running count is kept
        '{ROW_TICK,  16'hFFFF, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0001, 1'b0, 1'b0, 5'd0},
        // fault-free tick cuts the burst short and reloads the pause
        '{ROW_TICK,  16'h0000, 1'b0, 1'b0, 5'd0},
        // fault returns: sit out the pause, then resume the leftover count
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0002, 1'b0, 1'b0, 5'd0},
        // zero pause: back-to-back bursts
        '{ROW_PAUSE, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0001, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0001, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0001, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0001, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0001, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0001, 1'b0, 1'b0, 5'd0},
        // longest pause: a fault right after a clear tick stays dark
        '{ROW_PAUSE, 16'h00FF, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0000, 1'b0, 1'b0, 5'd0},
        '{ROW_TICK,  16'h0010, 1'b1, 1'b0, 5'd5}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fcl_flags_if flags_ch ();
    fcl_led_if   led_ch ();

    fault_code_led_flasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags_ch),
        .o_led   (led_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // typed expectation that travels with the tick on the flags channel
    logic      tick_typed;
    t_led_beat tick_want;

    // blink state as the bench sees it
    logic               led_q;
    logic [CODE_W-1:0]  code_q;
    logic [TOG_W-1:0]   tog_q;
    logic [PAUSE_W-1:0] pause_q;
    logic [PAUSE_W-1:0] pause_cfg;

    t_led_beat led_expected [$];
    int        fail_count = 0;
    bit        idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Advance the blink state by one tick and return the LED beat it gives.
    function automatic t_led_beat flasher_advance(input logic [FLAG_W-1:0] flags);
        t_led_beat beat;
        bit        found;
        found = 1'b0;
        if (flags != '0) begin
            for (int k = 0; k < FLAG_W; k++) begin
                if (!found && flags[k]) begin
                    code_q = CODE_W'(k + 1);
                    found  = 1'b1;
                end
            end
        end else begin
            code_q  = '0;
            pause_q = pause_cfg;
        end

        if (code_q == '0) begin
            led_q = ~led_q;
        end else if (pause_q != '0) begin
            pause_q = pause_q - 1'b1;
            led_q   = 1'b0;
        end else begin
            // a leftover count from a cut burst resumes without a reload
            if (tog_q == '0) begin
                tog_q = TOG_W'({code_q, 1'b0});
                led_q = 1'b0;
            end
            led_q = ~led_q;
            tog_q = tog_q - 1'b1;
            if (tog_q == '0) begin
                pause_q = pause_cfg;
                led_q   = 1'b0;
            end
        end
        beat.led  = led_q;
        beat.code = code_q;
        return beat;
    endfunction

    // Predict on every accepted tick, check every accepted LED beat.
    always @(posedge i_clk) begin
        t_led_beat want;
        if (i_rst_n) begin
            if (flags_ch.valid && flags_ch.ready) begin
                want = flasher_advance(flags_ch.fault_flags);
                if (tick_typed) begin
                    want = tick_want;
                end
                led_expected.push_back(want);
            end
            if (led_ch.valid && led_ch.ready) begin
                if (led_expected.size() == 0) begin
                    $error("LED beat with nothing pending: led_on %0d shown_code %0d",
                           led_ch.led_on, led_ch.shown_code);
                    fail_count++;
                end else begin
                    want = led_expected.pop_front();
                    if (led_ch.led_on !== want.led) begin
                        $error("led_on: expected %0d, got %0d", want.led, led_ch.led_on);
                        fail_count++;
                    end
                    if (led_ch.shown_code !== want.code) begin
                        $error("shown_code: expected %0d, got %0d",
                               want.code, led_ch.shown_code);
                        fail_count++;
                    end
                end
            end
        end
    end

    // LED side: ready high with random stall bursts while idling is on.
    initial begin
        int stall;
        stall = 0;
        led_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            // drop any leftover stall once idling is off
            if (!idle_on) begin
                stall = 0;
            end
            if (stall > 0) begin
                led_ch.ready <= 1'b0;
                stall--;
            end else begin
                led_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0) begin
                    stall = $urandom_range(1, 19);
                end
            end
        end
    end

    // Offer one tick, hold it until accepted. Valid stays high on return.
    task automatic send_tick(input logic [FLAG_W-1:0] flags, input logic typed,
                             input t_led_beat want);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            flags_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        flags_ch.valid       <= 1'b1;
        flags_ch.fault_flags <= flags;
        tick_typed           <= typed;
        tick_want            <= want;
        do @(posedge i_clk); while (!flags_ch.ready);
    endtask

    // Drop valid and hold until every pending LED beat has come back.
    task automatic wait_drain();
        flags_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (led_expected.size() != 0) @(posedge i_clk);
    endtask

    // Setup phase, then access phase; the write lands when pready is high.
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_PAUSE_TICKS) begin
            pause_cfg = value[PAUSE_W-1:0];
        end
    endtask

    task automatic set_pause(input logic [PAUSE_W-1:0] ticks);
        wait_drain();
        apb_write(REG_PAUSE_TICKS, APB_DATA_W'(ticks));
    endtask

    // Random phase: mostly runs of one fault code, some long enough to finish a
    // pause and a burst, salted with clear ticks and random bitmaps.
    task automatic run_phase(input int n_items, input bit idles);
        int                sent;
        int                run_len;
        int                k;
        int                roll;
        bit                quiet;
        logic [FLAG_W-1:0] low_bit;
        logic [FLAG_W-1:0] bm;
        t_led_beat         none;
        idle_on = idles;
        none    = '0;
        sent    = 0;
        while (sent < n_items) begin
            k       = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, FLAG_W - 1);
            low_bit = FLAG_W'(1) << k;
            quiet   = ($urandom_range(0, 9) == 0);
            run_len = $urandom_range(1, int'(pause_cfg) + 2 * (k + 1) + 4);
            if ($urandom_range(0, 3) == 0) begin
                run_len = run_len * 2;
            end
            for (int t = 0; t < run_len && sent < n_items; t++) begin
                roll = $urandom_range(0, 99);
                if (quiet || roll < 6) begin
                    bm = '0;
                end else if (roll < 11) begin
                    bm = FLAG_W'($urandom);
                end else begin
                    // keep the lowest set bit, scramble everything above it
                    bm = (FLAG_W'($urandom) & ~(low_bit - 1'b1)) | low_bit;
                end
                send_tick(bm, 1'b0, none);
                sent++;
                if (sent == n_items / 2) begin
                    wait_drain();
                end
            end
        end
    endtask

    initial begin
        t_led_beat want;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        flags_ch.valid       <= 1'b0;
        flags_ch.fault_flags <= '0;
        tick_typed           <= 1'b0;
        tick_want            <= '0;
        led_q     = 1'b0;
        code_q    = '0;
        tog_q     = '0;
        pause_q   = '0;
        pause_cfg = PAUSE_RESET;
        idle_on   = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the script
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (SCRIPT[r].kind == ROW_PAUSE) begin
                set_pause(SCRIPT[r].value[PAUSE_W-1:0]);
            end else begin
                want.led  = SCRIPT[r].led;
                want.code = SCRIPT[r].code;
                send_tick(SCRIPT[r].value, SCRIPT[r].typed, want);
            end
        end

        // random phases over a spread of pause settings
        set_pause(8'd0);
        run_phase(150, 1'b1);
        set_pause(8'd1);
        run_phase(150, 1'b0);
        set_pause(8'd255);
        run_phase(300, 1'b1);
        set_pause(PAUSE_W'($urandom_range(2, 15)));
        run_phase(150, 1'b1);
        set_pause(PAUSE_W'($urandom_range(0, 255)));
        run_phase(150, 1'b1);
        set_pause(8'd3);
        run_phase(150, 1'b1);
        // closing stretch runs at full rate on both sides
        set_pause(PAUSE_RESET);
        run_phase(200, 1'b0);

        wait_drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
